// ----- rtl/imufps_pkg.sv -----
// Shared types and constants for the motion sensor frame parser and scaler.
// No dependencies.
package imufps_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int WORD_W  = 16;
  localparam int AXIS_W  = 20;
  localparam int TEMP_W  = 16;
  localparam int KIND_W  = 2;
  localparam int TDATA_W = 80;

  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_LO  = 8'h51;
  localparam logic [7:0] TYPE_HI  = 8'h53;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACC  = 2'd0,
    KIND_RATE = 2'd1,
    KIND_ANG  = 2'd2
  } kind_t;

  // Raw frame handed from the parser to the scaler
  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] w0;
    logic signed [WORD_W-1:0] w1;
    logic signed [WORD_W-1:0] w2;
    logic signed [TEMP_W-1:0] temp;
  } frame_t;

endpackage

// ----- rtl/imufps_parser.sv -----
// Front end: hunts for frame header and type, collects payload bytes and
// pushes one raw frame per checksum byte. Depends on imufps_pkg.
module imufps_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // rx_byte[7:0]
  input  logic                   q_full,
  output logic                   q_push,
  output imufps_pkg::frame_t     q_data
);
  import imufps_pkg::*;

  localparam logic [3:0] POS_HUNT = 4'd0;
  localparam logic [3:0] POS_TYPE = 4'd1;
  localparam logic [3:0] POS_DAT0 = 4'd2;
  localparam logic [3:0] POS_DAT7 = 4'd9;
  localparam logic [3:0] POS_CSUM = 4'd10;

  logic [3:0]  pos;
  logic [3:0]  pos_next;
  kind_t       kind_held;
  logic [7:0]  payload [8];
  logic        accept;
  logic [2:0]  widx;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign widx     = pos[2:0] - 3'd2;
  assign q_push   = accept && (pos == POS_CSUM);

  always_comb begin
    q_data.kind = kind_held;
    q_data.w0   = {payload[1], payload[0]};
    q_data.w1   = {payload[3], payload[2]};
    q_data.w2   = {payload[5], payload[4]};
    q_data.temp = (kind_held == KIND_ANG) ? {payload[7], payload[6]} : '0;
  end

  always_comb begin
    pos_next = POS_HUNT;
    if (pos == POS_HUNT) begin
      pos_next = (s_tdata == HDR_BYTE) ? POS_TYPE : POS_HUNT;
    end else if (pos == POS_TYPE) begin
      pos_next = (s_tdata >= TYPE_LO && s_tdata <= TYPE_HI) ? POS_DAT0 : POS_HUNT;
    end else if (pos >= POS_DAT0 && pos <= POS_DAT7) begin
      pos_next = pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_HUNT;
      kind_held <= KIND_ACC;
    end else if (accept) begin
      pos <= pos_next;
      if (pos == POS_TYPE && pos_next == POS_DAT0) begin
        kind_held <= kind_t'(2'(s_tdata - TYPE_LO));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos >= POS_DAT0 && pos <= POS_DAT7) begin
      payload[widx] <= s_tdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_CSUM)
    else $error("parser position out of range");
  a_push_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("frame pushed into full queue");
  a_csum_wrap: assert property (@(posedge clk) disable iff (rst)
      q_push |=> pos == POS_HUNT)
    else $error("position not back to hunt after frame");
`endif

endmodule

// ----- rtl/imufps_queue.sv -----
// Short frame queue between parser and scaler, register based.
// Depends on imufps_pkg.
module imufps_queue #(
  parameter int DEPTH = imufps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  imufps_pkg::frame_t  push_data,
  output logic                full,
  input  logic                pop,
  output imufps_pkg::frame_t  pop_data,
  output logic                empty
);
  import imufps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count overflow");
  a_cnt_inc: assert property (@(posedge clk) disable iff (rst)
      do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count not advanced on push");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/imufps_scaler.sv -----
// Back end: multiplies raw axis words by the per-kind scale, then shifts,
// floors and saturates into the output register. Depends on imufps_pkg.
module imufps_scaler #(
  parameter int FRAC_BITS = imufps_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  imufps_pkg::frame_t  q_data,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [imufps_pkg::TDATA_W-1:0] m_tdata,  // x[19:0], y, z, temp_centi, pad
  output logic [imufps_pkg::KIND_W-1:0]  m_tuser   // frame_kind[1:0]
);
  import imufps_pkg::*;

  localparam int PROD_W = WORD_W + 8;
  localparam int WIDE_W = PROD_W + FRAC_BITS + 4;
  localparam logic signed [WIDE_W-1:0] QMAX = WIDE_W'(OUT_MAX);
  localparam logic signed [WIDE_W-1:0] QMIN = WIDE_W'(OUT_MIN);
  localparam int PAD_W = TDATA_W - 3 * AXIS_W - TEMP_W;

  // scale = mult * 2^exp : 16 = 1*2^4, 2000 = 125*2^4, 180 = 45*2^2
  logic signed [7:0]        mult;
  logic signed [PROD_W-1:0] prod [3];
  logic signed [WORD_W-1:0] word_in [3];

  logic                     s1_valid;
  kind_t                    s1_kind;
  logic signed [PROD_W-1:0] s1_prod [3];
  logic signed [TEMP_W-1:0] s1_temp;

  logic                     s1_take;
  logic                     out_load;
  logic [AXIS_W-1:0]        axis_sat [3];

  kind_t                    out_kind;
  logic [AXIS_W-1:0]        out_axis [3];
  logic signed [TEMP_W-1:0] out_temp;

  assign out_load = !m_tvalid || m_tready;
  assign s1_take  = !s1_valid || out_load;
  assign q_pop    = s1_take && !q_empty;

  assign word_in[0] = q_data.w0;
  assign word_in[1] = q_data.w1;
  assign word_in[2] = q_data.w2;

  always_comb begin
    case (q_data.kind)
      KIND_ACC:  mult = 8'sd1;
      KIND_RATE: mult = 8'sd125;
      KIND_ANG:  mult = 8'sd45;
      default:   mult = 8'sd45;
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [WIDE_W-1:0] ext;
    logic signed [WIDE_W-1:0] shifted;
    logic signed [WIDE_W-1:0] q;

    assign prod[i] = PROD_W'(word_in[i]) * PROD_W'(mult);

    always_comb begin
      ext = WIDE_W'(s1_prod[i]);
      if (s1_kind == KIND_ACC || s1_kind == KIND_RATE) begin
        shifted = ext <<< (FRAC_BITS + 4);
      end else begin
        shifted = ext <<< (FRAC_BITS + 2);
      end
      q = shifted >>> 15;
      if (q > QMAX) begin
        axis_sat[i] = QMAX[AXIS_W-1:0];
      end else if (q < QMIN) begin
        axis_sat[i] = QMIN[AXIS_W-1:0];
      end else begin
        axis_sat[i] = q[AXIS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= !q_empty;
      end
      if (out_load) begin
        m_tvalid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_kind <= q_data.kind;
      s1_temp <= q_data.temp;
      for (int i = 0; i < 3; i++) begin
        s1_prod[i] <= prod[i];
      end
    end
    if (out_load && s1_valid) begin
      out_kind <= s1_kind;
      out_temp <= s1_temp;
      for (int i = 0; i < 3; i++) begin
        out_axis[i] <= axis_sat[i];
      end
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_temp, out_axis[2], out_axis[1], out_axis[0]};
  assign m_tuser = out_kind;

`ifndef NO_ASSERTIONS
  a_temp_kind: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && out_kind != KIND_ANG |-> out_temp == '0)
    else $error("temperature set on non-angle frame");
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !out_load |=> s1_valid)
    else $error("stage one item dropped while stalled");
  a_s1_move: assert property (@(posedge clk) disable iff (rst)
      s1_valid && out_load |=> m_tvalid)
    else $error("stage one item not moved to output");
`endif

endmodule

// ----- rtl/imu_frame_parser_scaler.sv -----
// Top level of the motion sensor frame parser and scaler.
// Depends on imufps_pkg, imufps_parser, imufps_queue, imufps_scaler.
//
// Takes one serial byte per word on the s_ side at up to one byte per clock.
// A frame of 0x55, type 0x51..0x53, eight payload bytes and a checksum gives
// one word on the m_ side: three axes scaled to FRAC_BITS fraction bits,
// floored and saturated, plus temperature for angle frames. s_tready drops
// only while the frame queue holds QUEUE_DEPTH frames that the output side
// has not yet taken.
module imu_frame_parser_scaler #(
  parameter int FRAC_BITS   = imufps_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = imufps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // rx_byte[7:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [imufps_pkg::TDATA_W-1:0] m_tdata,  // x[19:0], y[39:20], z[59:40], temp[75:60]
  output logic [imufps_pkg::KIND_W-1:0]  m_tuser   // frame_kind[1:0]
);
  import imufps_pkg::*;

  frame_t push_data;
  frame_t pop_data;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  imufps_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  imufps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  imufps_scaler #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scaler (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- sim/testbench.sv -----
// Self-checking bench for imu_frame_parser_scaler: byte stream in, scaled frames out.
// Depends on imufps_pkg and the imu_frame_parser_scaler RTL; a predictor models the
// framing and fixed-point scaling, and a monitor checks every output word against it.
`timescale 1ns / 1ps

module testbench;
  import imufps_pkg::*;

  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int ACC_FULL    = 16;
  localparam int RATE_FULL   = 2000;
  localparam int ANG_FULL    = 180;
  localparam int SCALE_SHIFT = 15;
  localparam int PAYLOAD_POS = 2;
  localparam int SUM_POS     = 10;
  localparam int BYTE_TARGET = 1050;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    kind_t                    kind;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
    logic signed [TEMP_W-1:0] temp;
  } imu_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]  m_tuser;

  logic [7:0]  byte_q[$];
  imu_result_t expected_frames[$];

  int          rx_pos = 0;
  kind_t       kind_now = KIND_ACC;
  logic [7:0]  payload[8];

  logic        in_took = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          cycles = 0;

  imu_frame_parser_scaler #(.FRAC_BITS(FRAC)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [AXIS_W-1:0] scale_word(input logic signed [WORD_W-1:0] w,
                                                          input int full);
    longint q;
    q = (longint'(w) * full * (longint'(1) << FRAC)) >>> SCALE_SHIFT;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    return q[AXIS_W-1:0];
  endfunction

  task automatic track_rx_byte(input logic [7:0] b);
    imu_result_t r;
    logic [7:0]  code;
    int          full;
    case (rx_pos)
      0: rx_pos = (b == HDR_BYTE) ? 1 : 0;
      1: begin
        if (b >= TYPE_LO && b <= TYPE_HI) begin
          code = b - TYPE_LO;
          kind_now = kind_t'(code[1:0]);
          rx_pos = PAYLOAD_POS;
        end else begin
          rx_pos = 0;
        end
      end
      SUM_POS: begin
        case (kind_now)
          KIND_ACC:  full = ACC_FULL;
          KIND_RATE: full = RATE_FULL;
          default:   full = ANG_FULL;
        endcase
        r.kind = kind_now;
        r.x    = scale_word({payload[1], payload[0]}, full);
        r.y    = scale_word({payload[3], payload[2]}, full);
        r.z    = scale_word({payload[5], payload[4]}, full);
        r.temp = (kind_now == KIND_ANG) ? {payload[7], payload[6]} : '0;
        expected_frames.push_back(r);
        rx_pos = 0;
      end
      default: begin
        payload[rx_pos - PAYLOAD_POS] = b;
        rx_pos = rx_pos + 1;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic signed [AXIS_W-1:0] want,
                               input logic signed [AXIS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_frame();
    imu_result_t want;
    results_seen++;
    if (expected_frames.size() == 0) begin
      $error("frame_kind: expected none, got %0d", m_tuser);
      mismatches++;
    end else begin
      want = expected_frames.pop_front();
      compare_field("frame_kind", want.kind, m_tuser);
      compare_field("x_value", want.x, $signed(m_tdata[19:0]));
      compare_field("y_value", want.y, $signed(m_tdata[39:20]));
      compare_field("z_value", want.z, $signed(m_tdata[59:40]));
      compare_field("temp_centi", want.temp, $signed(m_tdata[75:60]));
    end
  endtask

  task automatic push_frame(input kind_t k, input logic [15:0] w0, input logic [15:0] w1,
                            input logic [15:0] w2, input logic [15:0] w3,
                            input logic [7:0] sum);
    byte_q.push_back(HDR_BYTE);
    byte_q.push_back(TYPE_LO + k);
    byte_q.push_back(w0[7:0]); byte_q.push_back(w0[15:8]);
    byte_q.push_back(w1[7:0]); byte_q.push_back(w1[15:8]);
    byte_q.push_back(w2[7:0]); byte_q.push_back(w2[15:8]);
    byte_q.push_back(w3[7:0]); byte_q.push_back(w3[15:8]);
    byte_q.push_back(sum);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return $urandom;
    endcase
  endfunction

  // sampling side: predictor on accepted bytes, checks on accepted frames
  always @(posedge clk) begin
    in_took <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) track_rx_byte(s_tdata);
    if (!rst && m_tvalid && m_tready) check_frame();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_took) begin
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (byte_q.size() > 0) begin
      s_tdata  <= byte_q.pop_front();
      s_tvalid <= 1'b1;
      gap_left <= pick_gap(tx_calm);
      if ($urandom_range(0, 99) == 0) tx_calm <= !tx_calm;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // long hold-off on the output so the frame queue fills and s_tready drops
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!rst && holds_done < 2 && results_seen >= (holds_done == 0 ? 20 : 55)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(negedge clk) begin
    if (rst || hold_left > 0) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap(rx_calm);
      if ($urandom_range(0, 199) == 0) rx_calm <= !rx_calm;
    end
  end

  initial begin
    logic [7:0] bad;
    int         r;
    int         n;

    // noise, bad type bytes, header as type byte
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'hAA);
    byte_q.push_back(HDR_BYTE); byte_q.push_back(TYPE_LO - 8'd1);
    byte_q.push_back(HDR_BYTE); byte_q.push_back(TYPE_HI + 8'd1);
    byte_q.push_back(HDR_BYTE); byte_q.push_back(HDR_BYTE);
    push_frame(KIND_ACC, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h1234, 8'h00);
    push_frame(KIND_RATE, 16'h7FFF, 16'h8000, 16'h0001, 16'h5555, 8'hFF);
    push_frame(KIND_ANG, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, HDR_BYTE);
    push_frame(KIND_ANG, 16'h0000, 16'h0080, 16'hFF80, 16'h7FFF, 8'hA5);

    while (byte_q.size() < BYTE_TARGET) begin
      r = $urandom_range(0, 9);
      if (r <= 6) begin
        push_frame(kind_t'($urandom_range(0, 2)), pick_word(), pick_word(), pick_word(),
                   pick_word(), $urandom);
      end else if (r == 7) begin
        n = $urandom_range(1, 4);
        repeat (n) byte_q.push_back($urandom);
      end else if (r == 8) begin
        bad = $urandom;
        while (bad >= TYPE_LO && bad <= TYPE_HI) bad = $urandom;
        byte_q.push_back(HDR_BYTE);
        byte_q.push_back(bad);
      end else begin
        byte_q.push_back(HDR_BYTE);
        push_frame(kind_t'($urandom_range(0, 2)), pick_word(), pick_word(), pick_word(),
                   pick_word(), $urandom);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (byte_q.size() == 0 && !s_tvalid);
    wait (expected_frames.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- imu_frame_parser_scaler.f -----
rtl/imufps_pkg.sv
rtl/imufps_parser.sv
rtl/imufps_queue.sv
rtl/imufps_scaler.sv
rtl/imu_frame_parser_scaler.sv
sim/testbench.sv
